### rtl/core/sle_pkg.sv
package sle_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int WORD_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_LOCATE = 2'd1,
    FN_GET    = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_SCAN,
    S_GETW
  } state_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

### rtl/core/sequential_list_engine_unit.sv
// Channel   Ports                                          Handshake
// request   func, position, item_value                     start high, busy low
// result    status, read_value, found_index, count, ...    done, one cycle
//
// Clear, refused requests and locate on an empty list never raise busy.
// Get: busy in S_GETW. Insert at p into n words: S_SHIFT, S_DRAIN, S_PUT; append: S_PUT.
// Locate: S_SCAN reads words in turn through the single read port, to a hit or the end.
// The done strobe follows the last busy cycle; rst is synchronous and empties the list.
// Results cannot be stalled; the receiver must take each word when done is high.
module sequential_list_engine_unit #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  func,
  input  logic [sle_pkg::POS_W-1:0]   position,
  input  logic signed [sle_pkg::WORD_W-1:0] item_value,
  output logic                        busy,
  output logic                        done,
  output logic [1:0]                  status,
  output logic signed [sle_pkg::WORD_W-1:0] read_value,
  output logic [sle_pkg::CNT_W-1:0]   found_index,
  output logic [sle_pkg::CNT_W-1:0]   count,
  output logic                        is_empty
);
  import sle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  mem_ctl_t mem_ctl;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] rd_word;

  assign read_value = rd_word;

  sle_ctrl #(
    .CAPACITY(CAPACITY),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .func(func),
    .position(position),
    .item_value(item_value),
    .busy(busy),
    .done(done),
    .status(status),
    .read_value(rd_word),
    .found_index(found_index),
    .count(count),
    .is_empty(is_empty),
    .mem_ctl(mem_ctl),
    .raddr(raddr),
    .waddr(waddr),
    .wdata(wdata),
    .rdata(rdata)
  );

  sle_ram #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .mem_ctl(mem_ctl),
    .raddr(raddr),
    .waddr(waddr),
    .wdata(wdata),
    .rdata(rdata)
  );

endmodule

### rtl/core/sle_ram.sv
module sle_ram #(
  parameter int DEPTH = sle_pkg::CAPACITY_DEF,
  parameter int AW = 5
) (
  input  logic                      clk,
  input  sle_pkg::mem_ctl_t         mem_ctl,
  input  logic [AW-1:0]             raddr,
  input  logic [AW-1:0]             waddr,
  input  logic [sle_pkg::WORD_W-1:0] wdata,
  output logic [sle_pkg::WORD_W-1:0] rdata
);
  import sle_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/sle_ctrl.sv
module sle_ctrl #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  func,
  input  logic [sle_pkg::POS_W-1:0]   position,
  input  logic [sle_pkg::WORD_W-1:0]  item_value,
  output logic                        busy,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [sle_pkg::WORD_W-1:0]  read_value,
  output logic [sle_pkg::CNT_W-1:0]   found_index,
  output logic [sle_pkg::CNT_W-1:0]   count,
  output logic                        is_empty,
  output sle_pkg::mem_ctl_t           mem_ctl,
  output logic [AW-1:0]               raddr,
  output logic [AW-1:0]               waddr,
  output logic [sle_pkg::WORD_W-1:0]  wdata,
  input  logic [sle_pkg::WORD_W-1:0]  rdata
);
  import sle_pkg::*;

  localparam int PW = (CW > POS_W) ? CW + 1 : POS_W + 1;

  state_t state, state_next;
  logic [CW-1:0] live_count, live_count_next;
  logic [CW-1:0] idx, idx_next;
  logic [WORD_W-1:0] key;
  logic [AW-1:0] ins_addr;
  logic wr_pend, wr_pend_next;
  logic [AW-1:0] wr_pend_addr, wr_pend_addr_next;
  logic cmp_pend, cmp_pend_next;
  logic [AW-1:0] cmp_idx;

  logic res_valid;
  status_t res_status;
  logic [WORD_W-1:0] res_read;
  logic [PW-1:0] res_found;

  func_t fn;
  logic [PW-1:0] cnt_ext, pos_ext, pos_m1, cnt_next_ext;
  logic ins_full, ins_bad, get_bad, append, hit, scan_end, shift_last;

  assign fn = func_t'(func);
  assign cnt_ext = PW'(live_count);
  assign pos_ext = PW'(position);
  assign pos_m1 = pos_ext - PW'(1);
  assign ins_full = (live_count == CW'(CAPACITY));
  assign ins_bad = (position == '0) || (pos_ext > cnt_ext + PW'(1));
  assign get_bad = (position == '0) || (pos_ext > cnt_ext);
  assign append = (pos_ext == cnt_ext + PW'(1));
  assign hit = cmp_pend && (rdata == key);
  assign scan_end = (idx == live_count);
  assign shift_last = (idx[AW-1:0] == ins_addr);
  assign busy = (state != S_IDLE);
  assign cnt_next_ext = PW'(live_count_next);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (fn)
            FN_INSERT: begin
              if (!ins_full && !ins_bad) begin
                state_next = append ? S_PUT : S_SHIFT;
              end
            end
            FN_LOCATE: begin
              if (live_count != '0) begin
                state_next = S_SCAN;
              end
            end
            FN_GET: begin
              if (!get_bad) begin
                state_next = S_GETW;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_PUT;
      S_PUT:   state_next = S_IDLE;
      S_SCAN: begin
        if (hit || scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_GETW:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl = '0;
    raddr = idx[AW-1:0];
    waddr = wr_pend_addr;
    wdata = rdata;
    idx_next = idx;
    live_count_next = live_count;
    res_valid = 1'b0;
    res_status = ST_OK;
    res_read = '0;
    res_found = '0;
    if (wr_pend) begin
      mem_ctl.we = 1'b1;
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          case (fn)
            FN_INSERT: begin
              if (ins_full) begin
                res_valid = 1'b1;
                res_status = ST_FULL;
              end else if (ins_bad) begin
                res_valid = 1'b1;
                res_status = ST_BADPOS;
              end else begin
                idx_next = live_count - CW'(1);
              end
            end
            FN_LOCATE: begin
              if (live_count == '0) begin
                res_valid = 1'b1;
                res_status = ST_NOTFOUND;
              end else begin
                idx_next = '0;
              end
            end
            FN_GET: begin
              if (get_bad) begin
                res_valid = 1'b1;
                res_status = ST_BADPOS;
              end else begin
                mem_ctl.re = 1'b1;
                raddr = pos_m1[AW-1:0];
              end
            end
            default: begin
              live_count_next = '0;
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_ctl.re = 1'b1;
        idx_next = idx - CW'(1);
      end
      S_PUT: begin
        mem_ctl.we = 1'b1;
        waddr = ins_addr;
        wdata = key;
        live_count_next = live_count + CW'(1);
        res_valid = 1'b1;
      end
      S_SCAN: begin
        if (hit) begin
          res_valid = 1'b1;
          res_found = PW'(cmp_idx) + PW'(1);
        end else if (scan_end) begin
          res_valid = 1'b1;
          res_status = ST_NOTFOUND;
        end else begin
          mem_ctl.re = 1'b1;
          idx_next = idx + CW'(1);
        end
      end
      S_GETW: begin
        res_valid = 1'b1;
        res_read = rdata;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    wr_pend_next = (state == S_SHIFT);
    wr_pend_addr_next = idx[AW-1:0] + AW'(1);
    cmp_pend_next = (state == S_SCAN) && mem_ctl.re;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live_count <= '0;
      wr_pend <= 1'b0;
      cmp_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      live_count <= live_count_next;
      wr_pend <= wr_pend_next;
      cmp_pend <= cmp_pend_next;
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    wr_pend_addr <= wr_pend_addr_next;
    cmp_idx <= idx[AW-1:0];
    if (start && (state == S_IDLE)) begin
      key <= item_value;
      ins_addr <= pos_m1[AW-1:0];
    end
    if (res_valid) begin
      status <= res_status;
      read_value <= res_read;
      found_index <= res_found[CNT_W-1:0];
      count <= cnt_next_ext[CNT_W-1:0];
      is_empty <= (live_count_next == '0);
    end
  end

  a_no_rw_same: assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.we && mem_ctl.re) |-> (waddr != raddr))
    else $error("read and write to the same entry in one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    live_count <= CW'(CAPACITY))
    else $error("live count exceeds capacity");

  a_put_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> !wr_pend)
    else $error("shift write still pending when the new word is stored");

  a_put_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |=> (done && (status == ST_OK)))
    else $error("insert finished without an ok result");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (found_index != '0)) |-> (status == ST_OK))
    else $error("nonzero found index with a failing status");

endmodule

### test/sequential_list_engine_unit_tb.sv
module sequential_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int RANDOM_WORDS = 1100;
  localparam int DRAIN_CYCLES = CAP + 16;

  typedef struct {
    status_t            status;
    logic signed [31:0] read_value;
    logic [5:0]         found_index;
    logic [5:0]         count;
    logic               is_empty;
  } list_reply_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [1:0]                func = FN_INSERT;
  logic [POS_W-1:0]          position = '0;
  logic signed [WORD_W-1:0]  item_value = '0;
  logic                      busy;
  logic                      done;
  logic [1:0]                status;
  logic signed [WORD_W-1:0]  read_value;
  logic [CNT_W-1:0]          found_index;
  logic [CNT_W-1:0]          count;
  logic                      is_empty;

  logic signed [31:0] list_words [CAP];
  int                 list_len = 0;
  list_reply_t        expected_words [$];
  int                 errors = 0;
  int                 words_sent = 0;
  int                 burst_left = 0;

  sequential_list_engine_unit #(.CAPACITY(CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .func(func),
    .position(position),
    .item_value(item_value),
    .busy(busy),
    .done(done),
    .status(status),
    .read_value(read_value),
    .found_index(found_index),
    .count(count),
    .is_empty(is_empty)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void apply_list_op(func_t op, logic [5:0] pos, logic signed [31:0] val);
    list_reply_t r;
    int p;
    p = pos;
    r.status = ST_OK;
    r.read_value = '0;
    r.found_index = '0;
    case (op)
      FN_INSERT: begin
        if (list_len >= CAP) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (int k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = val;
          list_len++;
        end
      end
      FN_LOCATE: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k < list_len; k++) begin
          if (list_words[k] == val) begin
            r.status = ST_OK;
            r.found_index = 6'(k + 1);
            break;
          end
        end
      end
      FN_GET: begin
        if (p < 1 || p > list_len) r.status = ST_BADPOS;
        else r.read_value = list_words[p-1];
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.count = 6'(list_len);
    r.is_empty = (list_len == 0);
    expected_words.push_back(r);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // The sender runs in bursts; between bursts start may drop for a random gap.
  task automatic send_word(func_t op, int pos, logic signed [31:0] val);
    int gap;
    start <= 1'b1;
    func <= op;
    position <= POS_W'(pos);
    item_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    apply_list_op(op, 6'(pos), val);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3, 4, 5, 6, 7: gap = $urandom_range(1, 5);
        default: gap = $urandom_range(6, 40);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && done === 1'b1) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual status %0d count %0d",
                 $time, status, count);
      end else begin
        want = expected_words.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("read_value", want.read_value, read_value);
        check_field("found_index", 32'(want.found_index), 32'(found_index));
        check_field("count", 32'(want.count), 32'(count));
        check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
      end
    end
  end

  task automatic test_empty_list();
    send_word(FN_GET, 0, 0);
    send_word(FN_GET, 1, 0);
    send_word(FN_LOCATE, 0, 0);
    send_word(FN_INSERT, 0, 5);
    send_word(FN_INSERT, 2, 5);
    send_word(FN_CLEAR, 63, 32'hFFFF_FFFF);
  endtask

  task automatic test_small_list_edges();
    send_word(FN_INSERT, 1, 32'h8000_0000);
    send_word(FN_INSERT, 2, 32'h7FFF_FFFF);
    send_word(FN_INSERT, 1, 0);
    send_word(FN_INSERT, 2, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 63, 1);
    send_word(FN_INSERT, 3, 32'hFFFF_FFFF);
    send_word(FN_GET, 1, 0);
    send_word(FN_GET, 5, 0);
    send_word(FN_GET, 6, 0);
    send_word(FN_GET, 63, 0);
    send_word(FN_LOCATE, 0, 32'hFFFF_FFFF);
    send_word(FN_LOCATE, 0, 32'h7FFF_FFFF);
    send_word(FN_LOCATE, 63, 12345);
    send_word(FN_CLEAR, 0, 0);
    send_word(FN_GET, 1, 0);
    send_word(FN_LOCATE, 0, 32'h8000_0000);
  endtask

  task automatic test_full_list();
    while (list_len < CAP) send_word(FN_INSERT, $urandom_range(1, list_len + 1), pick_value());
    send_word(FN_INSERT, 1, 7);
    send_word(FN_INSERT, 0, 7);
    send_word(FN_INSERT, 63, 7);
    send_word(FN_GET, CAP, 0);
    send_word(FN_GET, CAP + 1, 0);
    send_word(FN_LOCATE, 0, list_words[CAP-1]);
    send_word(FN_LOCATE, 0, 32'h1234_5678);
    send_word(FN_CLEAR, $urandom_range(0, 63), $urandom);
  endtask

  task automatic test_random_traffic();
    int target;
    int ops;
    int pick;
    logic signed [31:0] key;
    while (words_sent < RANDOM_WORDS) begin
      target = ($urandom_range(0, 1) == 1) ? CAP : $urandom_range(1, CAP - 1);
      ops = target * 2 + $urandom_range(5, 40);
      repeat (ops) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_word(func_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom);
        end else if (pick < 50) begin
          if (list_len < target)
            send_word(FN_INSERT, $urandom_range(1, list_len + 1), pick_value());
          else
            send_word(FN_INSERT, $urandom_range(0, 63), pick_value());
        end else if (pick < 75) begin
          if (list_len > 0 && $urandom_range(0, 2) != 0)
            key = list_words[$urandom_range(0, list_len - 1)];
          else
            key = pick_value();
          send_word(FN_LOCATE, $urandom_range(0, 63), key);
        end else begin
          if (list_len > 0 && $urandom_range(0, 4) != 0)
            send_word(FN_GET, $urandom_range(1, list_len), $urandom);
          else
            send_word(FN_GET, $urandom_range(0, 63), $urandom);
        end
      end
      send_word(FN_CLEAR, $urandom_range(0, 63), $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_empty_list();
    test_small_list_edges();
    test_full_list();
    test_random_traffic();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sle_ctrl.sv
rtl/core/sequential_list_engine_unit.sv
test/sequential_list_engine_unit_tb.sv
